>>> hdl/soct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soct_pkg
// shared sizes, codes and the travelling word type of the counter table
// ----------------------------------------------------------------------------
package soct_pkg;

	localparam int DEPTH      = 64;
	localparam int ID_BITS    = 16;
	localparam int COUNT_BITS = 16;

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	// fixed field widths at the ports
	localparam int ID_FW     = 16;
	localparam int RANK_FW   = 6;
	localparam int POS_FW    = 6;
	localparam int COUNT_FW  = 16;
	localparam int USED_FW   = 7;
	localparam int STATUS_FW = 3;

	localparam int RCMP_W = (IDX_W > RANK_FW) ? IDX_W : RANK_FW;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	localparam logic [STATUS_FW-1:0] ST_NEW   = 3'd0;
	localparam logic [STATUS_FW-1:0] ST_INC   = 3'd1;
	localparam logic [STATUS_FW-1:0] ST_FULL  = 3'd2;
	localparam logic [STATUS_FW-1:0] ST_READ  = 3'd3;
	localparam logic [STATUS_FW-1:0] ST_EMPTY = 3'd4;

	localparam logic [1:0] MODE_SEARCH = 2'd0;
	localparam logic [1:0] MODE_SHIFT  = 2'd1;
	localparam logic [1:0] MODE_DONE   = 2'd2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// operation word handed from cell to cell
	typedef struct packed {
		logic                  active;
		logic                  op;
		logic [1:0]            mode;
		logic [ID_BITS-1:0]    id;
		logic [RANK_FW-1:0]    rank;
		logic [FILL_W-1:0]     fill;
		logic [ID_BITS-1:0]    c_id;
		logic [COUNT_BITS-1:0] c_cnt;
		logic [STATUS_FW-1:0]  status;
		logic [POS_FW-1:0]     pos;
		logic [ID_BITS-1:0]    r_id;
		logic [COUNT_BITS-1:0] r_cnt;
	} tok_t;

endpackage
`default_nettype wire

>>> hdl/soct_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// soct_cell
// one table slot: compares the passing word, reads, counts, inserts or shifts
// ----------------------------------------------------------------------------
module soct_cell (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       en,
	input  wire  [soct_pkg::IDX_W-1:0] index,
	input  soct_pkg::tok_t            tok_in,
	output soct_pkg::tok_t            tok_out
);
	import soct_pkg::*;

	logic [ID_BITS-1:0]    id_q;
	logic [COUNT_BITS-1:0] cnt_q;
	tok_t                  tok_q;

	tok_t                  nt;
	logic                  wr;
	logic [ID_BITS-1:0]    nid;
	logic [COUNT_BITS-1:0] ncnt;
	logic                  valid;
	logic                  full;
	logic [COUNT_BITS-1:0] sat;

	assign valid = FILL_W'(index) < tok_in.fill;
	assign full  = tok_in.fill == FILL_W'(DEPTH);
	assign sat   = (cnt_q != COUNT_MAX) ? cnt_q + 1'b1 : cnt_q;

	always_comb begin
		nt   = tok_in;
		wr   = 1'b0;
		nid  = tok_in.id;
		ncnt = COUNT_BITS'(1);
		if (tok_in.active) begin
			if (tok_in.op == OP_READ) begin
				if (tok_in.mode == MODE_SEARCH && RCMP_W'(index) == RCMP_W'(tok_in.rank)) begin
					nt.mode = MODE_DONE;
					if (valid) begin
						nt.status = ST_READ;
						nt.r_id   = id_q;
						nt.r_cnt  = cnt_q;
					end
				end
			end else begin
				case (tok_in.mode)
					MODE_SEARCH: begin
						if (!valid) begin
							wr        = 1'b1;
							nt.status = ST_NEW;
							nt.pos    = POS_FW'(index);
							nt.r_id   = tok_in.id;
							nt.r_cnt  = COUNT_BITS'(1);
							nt.mode   = MODE_DONE;
						end else if (id_q == tok_in.id) begin
							wr        = 1'b1;
							nid       = id_q;
							ncnt      = sat;
							nt.status = ST_INC;
							nt.pos    = POS_FW'(index);
							nt.r_id   = tok_in.id;
							nt.r_cnt  = sat;
							nt.mode   = MODE_DONE;
						end else if (id_q > tok_in.id) begin
							if (full) begin
								// new id, no room: leave the table alone
								nt.mode = MODE_DONE;
							end else begin
								wr        = 1'b1;
								nt.c_id   = id_q;
								nt.c_cnt  = cnt_q;
								nt.status = ST_NEW;
								nt.pos    = POS_FW'(index);
								nt.r_id   = tok_in.id;
								nt.r_cnt  = COUNT_BITS'(1);
								nt.mode   = MODE_SHIFT;
							end
						end
					end
					MODE_SHIFT: begin
						wr   = 1'b1;
						nid  = tok_in.c_id;
						ncnt = tok_in.c_cnt;
						if (!valid) begin
							nt.mode = MODE_DONE;
						end else begin
							nt.c_id  = id_q;
							nt.c_cnt = cnt_q;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (en) begin
			tok_q <= nt;
		end
	end

	always_ff @(posedge clk) begin
		if (en && wr) begin
			id_q  <= nid;
			cnt_q <= ncnt;
		end
	end

	assign tok_out = tok_q;

endmodule
`default_nettype wire

>>> hdl/sorted_occurrence_counter_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_occurrence_counter_table
// ascending table of document ids with saturating occurrence counts
// ----------------------------------------------------------------------------
// input words arrive on s_*: s_tuser picks insert (0) or read at rank (1),
// s_tdata carries the document id and the rank. each word produces one
// result word on m_*: m_tuser gives the status, m_tdata the rank touched,
// the entry id and count and the number of entries held afterwards.
// the table is a row of DEPTH cells, one entry each, kept in ascending
// order. an accepted word walks the row one cell per cycle while the row is
// not frozen; the cell that holds the id counts it, the cell where a new id
// belongs takes it and the displaced entries ripple up one cell per cycle,
// carried along in the word. the result passes every cell register of
// the row and then the output register before m_tvalid rises. one word is
// in the row at a time, so a new word is taken the cycle after the
// previous one leaves the row.
// reset empties the table (fill count to zero); no clearing pass is needed.
// when the receiver stalls, the result waits in the output register and a
// following word may enter; the row freezes only while a finished word
// cannot leave it.
// ----------------------------------------------------------------------------
module sorted_occurrence_counter_table (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // doc_id[15:0], rank[21:16], zero pad
	input  wire  [0:0]  s_tuser,   // operation
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,   // position[5:0], entry_id[21:6],
	                               // entry_count[37:22], entries_used[44:38], zero pad
	output logic [2:0]  m_tuser    // status
);
	import soct_pkg::*;

	tok_t tok [0:DEPTH];
	tok_t tok_launch;

	logic                 busy_q;
	logic [FILL_W-1:0]    fill_q;
	logic                 m_tvalid_q;
	logic [STATUS_FW-1:0] status_q;
	logic [POS_FW-1:0]    pos_q;
	logic [ID_FW-1:0]     id_q;
	logic [COUNT_FW-1:0]  cnt_q;
	logic [USED_FW-1:0]   used_q;

	logic                 accept;
	logic                 en;
	logic                 leave;
	logic [FILL_W-1:0]    fill_next;
	logic [ID_BITS-1:0]   in_id;
	logic [RANK_FW-1:0]   in_rank;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;

	// the row only stops while its finished word is blocked at the output
	assign en    = !(tok[DEPTH].active && m_tvalid_q && !m_tready);
	assign leave = en && tok[DEPTH].active;

	assign in_id   = ID_BITS'(s_tdata[15:0]);
	assign in_rank = s_tdata[21:16];

	// launch word: status preset to what holds if no cell claims it
	always_comb begin
		tok_launch        = '0;
		tok_launch.active = accept;
		tok_launch.op     = s_tuser[0];
		tok_launch.mode   = MODE_SEARCH;
		tok_launch.id     = in_id;
		tok_launch.rank   = in_rank;
		tok_launch.fill   = fill_q;
		if (s_tuser[0] == OP_READ) begin
			tok_launch.status = ST_EMPTY;
			tok_launch.pos    = POS_FW'(in_rank);
		end else begin
			tok_launch.status = ST_FULL;
			tok_launch.r_id   = in_id;
		end
	end

	assign tok[0] = tok_launch;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			soct_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.index   (IDX_W'(g)),
				.tok_in  (tok[g]),
				.tok_out (tok[g+1])
			);
		end
	endgenerate

	assign fill_next = (tok[DEPTH].status == ST_NEW) ? fill_q + 1'b1 : fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			fill_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (leave) begin
				busy_q <= 1'b0;
			end
			if (leave) begin
				fill_q     <= fill_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (leave) begin
			status_q <= tok[DEPTH].status;
			pos_q    <= tok[DEPTH].pos;
			id_q     <= ID_FW'(tok[DEPTH].r_id);
			cnt_q    <= COUNT_FW'(tok[DEPTH].r_cnt);
			used_q   <= USED_FW'(fill_next);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = {3'b000, used_q, cnt_q, id_q, pos_q};

endmodule
`default_nettype wire

>>> tb/tb_sorted_occurrence_counter_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_occurrence_counter_table
// self-checking bench for the sorted occurrence counter table
// ----------------------------------------------------------------------------
// words go in through the slave stream with random gaps, and results come
// back through the master stream with random stalls. a behavioural copy of
// the table (ids in ascending order, counts, fill level) works out the
// result of each accepted word, and the checker compares every result word
// field by field with the oldest expected one. the run goes through a short
// directed part, a random part on a partly filled table, filling to the
// top, and a random part on a full table.
// ----------------------------------------------------------------------------
module tb_sorted_occurrence_counter_table;

	import soct_pkg::*;

	localparam int STALL_LIMIT = 4000;   // cycles with no word moving on either side
	localparam int TAIL_CYCLES = DEPTH + 16;

	// one expected result word, fields as they leave the block
	typedef struct packed {
		logic [STATUS_FW-1:0] status;
		logic [POS_FW-1:0]    position;
		logic [ID_FW-1:0]     entry_id;
		logic [COUNT_FW-1:0]  entry_count;
		logic [USED_FW-1:0]   entries_used;
	} tally_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;      // doc_id[15:0], rank[21:16], zero pad
	logic [0:0]  s_tuser = '0;      // operation
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;           // position[5:0], entry_id[21:6], entry_count[37:22],
	                                // entries_used[44:38], zero pad
	logic [2:0]  m_tuser;           // status

	// model of the table contents
	logic [ID_FW-1:0]    shadow_id [DEPTH];
	logic [COUNT_FW-1:0] shadow_cnt [DEPTH];
	int                  shadow_fill = 0;

	tally_t pending_tallies [$];

	int fail_count   = 0;
	int words_sent   = 0;
	int seen_new     = 0;
	int seen_inc     = 0;
	int seen_full    = 0;
	int seen_read    = 0;
	int seen_empty   = 0;
	int peak_count   = 0;
	int quiet_cycles = 0;
	int steady_left  = 0;   // words still to send back to back
	int sink_hold    = 0;
	int sink_roll;

	sorted_occurrence_counter_table uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------------
	// table model: applies one word and returns the result it should give
	// ------------------------------------------------------------------------
	function automatic tally_t tally_word(input logic op, input logic [ID_FW-1:0] id,
	                                      input logic [RANK_FW-1:0] rank);
		tally_t t;
		int     p;
		int     k;
		t = '0;
		if (op == OP_READ) begin
			t.position = rank;
			if (int'(rank) < shadow_fill) begin
				t.status      = ST_READ;
				t.entry_id    = shadow_id[rank];
				t.entry_count = shadow_cnt[rank];
			end else begin
				t.status = ST_EMPTY;
			end
		end else begin
			// first held id not below the new one
			p = 0;
			while (p < shadow_fill && shadow_id[p] < id)
				p++;
			if (p < shadow_fill && shadow_id[p] == id) begin
				if (shadow_cnt[p] != COUNT_MAX)
					shadow_cnt[p] = shadow_cnt[p] + 1'b1;
				t.status      = ST_INC;
				t.position    = POS_FW'(p);
				t.entry_id    = id;
				t.entry_count = shadow_cnt[p];
			end else if (shadow_fill >= DEPTH) begin
				// no room: dropped, reported at rank 0 with a zero count
				t.status   = ST_FULL;
				t.entry_id = id;
			end else begin
				for (k = shadow_fill; k > p; k--) begin
					shadow_id[k]  = shadow_id[k-1];
					shadow_cnt[k] = shadow_cnt[k-1];
				end
				shadow_id[p]  = id;
				shadow_cnt[p] = COUNT_FW'(1);
				shadow_fill++;
				t.status      = ST_NEW;
				t.position    = POS_FW'(p);
				t.entry_id    = id;
				t.entry_count = COUNT_FW'(1);
			end
		end
		t.entries_used = USED_FW'(shadow_fill);
		return t;
	endfunction

	// mostly short gaps, a few long ones, now and then a back-to-back run
	function automatic int pick_gap();
		int roll;
		if (steady_left > 0) begin
			steady_left--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 3) begin
			steady_left = $urandom_range(20, 60);
			return 0;
		end
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 100);
	endfunction

	// ------------------------------------------------------------------------
	// sender: one word, held until accepted; with no gap valid stays high for the next word
	// ------------------------------------------------------------------------
	task automatic offer_word(input logic op, input logic [ID_FW-1:0] id,
	                          input logic [RANK_FW-1:0] rank);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, rank, id};
		s_tuser  <= op;
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		pending_tallies.push_back(tally_word(op, id, rank));
		words_sent++;
	endtask

	task automatic offer_insert(input logic [ID_FW-1:0] id);
		offer_word(OP_INSERT, id, RANK_FW'($urandom_range(0, 63)));
	endtask

	task automatic offer_read(input logic [RANK_FW-1:0] rank);
		offer_word(OP_READ, ID_FW'($urandom_range(0, 65535)), rank);
	endtask

	// sender goes quiet until every outstanding result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_tallies.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// test tasks
	// ------------------------------------------------------------------------

	// empty reads, inserts at both ends and in the middle, repeats, reads past fill
	task automatic test_directed();
		int r;
		offer_read(6'd0);
		offer_read(6'd63);
		offer_insert(16'h8000);
		offer_insert(16'h0000);   // goes in below, shifts the first entry
		offer_insert(16'hFFFF);   // lands at the top end
		offer_insert(16'h8000);
		offer_insert(16'h0000);
		offer_insert(16'h4000);   // middle slot, upper entries move up
		offer_insert(16'hFFFF);
		offer_insert(16'h0001);
		offer_insert(16'hFFFE);
		offer_insert(16'h5555);
		offer_insert(16'hAAAA);
		for (r = 0; r < 9; r++)
			offer_read(RANK_FW'(r));
		offer_read(6'd9);         // past the fill level
		offer_read(6'd63);
	endtask

	// mixed traffic on a table that is not yet full; a skewed pool of ids
	// makes some counts climb well above one
	task automatic test_random_partial(input int n);
		logic [ID_FW-1:0] pool [40];
		int               i;
		int               roll;
		int               idx;
		for (i = 0; i < 40; i++)
			pool[i] = ID_FW'($urandom_range(0, 65535));
		for (i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 63) begin
				idx = $urandom_range(0, 39);
				if ($urandom_range(0, 1))
					idx = idx % 8;
				offer_insert(pool[idx]);
			end else if (roll < 65) begin
				offer_insert(ID_FW'($urandom_range(0, 65535)));
			end else if (roll < 90 && shadow_fill > 0) begin
				offer_read(RANK_FW'($urandom_range(0, shadow_fill - 1)));
			end else begin
				offer_read(RANK_FW'($urandom_range(0, 63)));
			end
		end
	endtask

	// new ids until every slot is taken, then a read of the top rank and inserts at both ends
	task automatic test_fill_up();
		while (shadow_fill < DEPTH)
			offer_insert(ID_FW'($urandom_range(0, 65535)));
		offer_read(6'd63);
		offer_insert(16'h0000);
		offer_insert(16'hFFFF);
	endtask

	// full table: new ids are dropped, held ids keep counting, reads at any rank
	task automatic test_random_full(input int n);
		int i;
		int roll;
		for (i = 0; i < n; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < 35)
				offer_insert(ID_FW'($urandom_range(0, 65535)));
			else if (roll < 70)
				offer_insert(shadow_id[IDX_W'($urandom_range(0, DEPTH - 1))]);
			else
				offer_read(RANK_FW'($urandom_range(0, 63)));
		end
	endtask

	// ------------------------------------------------------------------------
	// receiver: ready stretches, short stalls and the odd long one
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
		end else begin
			sink_roll = $urandom_range(0, 99);
			if (sink_roll < 60) begin
				m_tready  <= 1'b1;
				sink_hold <= $urandom_range(0, 40);
			end else if (sink_roll < 95) begin
				m_tready  <= 1'b0;
				sink_hold <= $urandom_range(0, 3);
			end else begin
				m_tready  <= 1'b0;
				sink_hold <= $urandom_range(20, 120);
			end
		end
	end

	// ------------------------------------------------------------------------
	// checker: each result word against the oldest expectation
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		tally_t want;
		tally_t got;
		if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
			got.status       = m_tuser;
			got.position     = m_tdata[5:0];
			got.entry_id     = m_tdata[21:6];
			got.entry_count  = m_tdata[37:22];
			got.entries_used = m_tdata[44:38];
			if (pending_tallies.size() == 0) begin
				$error("result word with nothing expected: status %0d", got.status);
				fail_count++;
			end else begin
				want = pending_tallies.pop_front();
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					fail_count++;
				end
				if (got.position !== want.position) begin
					$error("position: expected %0d, got %0d", want.position, got.position);
					fail_count++;
				end
				if (got.entry_id !== want.entry_id) begin
					$error("entry_id: expected %0h, got %0h", want.entry_id, got.entry_id);
					fail_count++;
				end
				if (got.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d",
					       want.entry_count, got.entry_count);
					fail_count++;
				end
				if (got.entries_used !== want.entries_used) begin
					$error("entries_used: expected %0d, got %0d",
					       want.entries_used, got.entries_used);
					fail_count++;
				end
				case (want.status)
					ST_NEW:   seen_new++;
					ST_INC:   seen_inc++;
					ST_FULL:  seen_full++;
					ST_READ:  seen_read++;
					default:  seen_empty++;
				endcase
				if (want.status == ST_INC && int'(want.entry_count) > peak_count)
					peak_count = int'(want.entry_count);
			end
		end
	end

	// watchdog: too long with no word moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		drain_results();
		test_random_partial(600);
		drain_results();
		test_fill_up();
		drain_results();
		test_random_full(700);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d words: %0d new, %0d counted (peak count %0d), %0d dropped full,",
		         words_sent, seen_new, seen_inc, peak_count, seen_full);
		$display("%0d reads of held entries and %0d reads past the fill level",
		         seen_read, seen_empty);
		if (fail_count == 0 && pending_tallies.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> files.f
hdl/soct_pkg.sv
hdl/soct_cell.sv
hdl/sorted_occurrence_counter_table.sv
tb/tb_sorted_occurrence_counter_table.sv
